FILE: hw/rtl/crc24a_pkg.sv
`default_nettype none

package crc24a_pkg;

    // Message byte width and remainder width
    localparam int DATA_WIDTH = 8;
    localparam int CRC_BITS   = 24;

    // Generator x^24 + ... + 1 without its leading term
    localparam logic [CRC_BITS-1:0] CRC_POLY_LOW = 24'h864CFB;

    // Number of trailer bytes appended after the last message byte
    localparam int TRAILER_BYTES = CRC_BITS / DATA_WIDTH;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] in_byte;
        logic                  in_last;
    } in_item_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] out_byte;
        logic                  out_last;
    } out_item_t;

    // One queue entry: the echoed byte, its last flag and the trailer bits
    // already ordered for transmission (bit j holds the x^(23-j) term)
    typedef struct packed {
        logic [DATA_WIDTH-1:0] msg_byte;
        logic                  last;
        logic [CRC_BITS-1:0]   trailer;
    } queue_entry_t;

    // Queue status seen by the back end
    typedef struct packed {
        logic         not_empty;
        queue_entry_t head;
    } queue_status_t;

    // Shift one byte into the remainder, bit 0 first
    function automatic logic [CRC_BITS-1:0] crc24a_update(
        input logic [CRC_BITS-1:0]   rem_in,
        input logic [DATA_WIDTH-1:0] data
    );
        logic [CRC_BITS-1:0] rem;
        logic                fb;
        rem = rem_in;
        for (int j = 0; j < DATA_WIDTH; j++)
        begin
            fb  = rem[CRC_BITS-1] ^ data[j];
            rem = {rem[CRC_BITS-2:0], 1'b0} ^ (fb ? CRC_POLY_LOW : '0);
        end
        return rem;
    endfunction

    // Reverse the remainder so the highest-degree term lands in bit 0
    function automatic logic [CRC_BITS-1:0] crc24a_reverse(
        input logic [CRC_BITS-1:0] rem
    );
        logic [CRC_BITS-1:0] rev;
        for (int j = 0; j < CRC_BITS; j++)
        begin
            rev[j] = rem[CRC_BITS-1-j];
        end
        return rev;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/crc24a_front.sv
`default_nettype none

module crc24a_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic                   cfg_wdata,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire crc24a_pkg::in_item_t   in_item,
    input  wire logic                   q_full,
    output logic                        q_push,
    output crc24a_pkg::queue_entry_t    q_entry
);
    import crc24a_pkg::*;

    logic                enable_reg;
    logic [CRC_BITS-1:0] remainder_reg;
    logic [CRC_BITS-1:0] remainder_next;
    logic [CRC_BITS-1:0] updated;
    logic                accept;

    // Stall while the queue has no room
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept;

    // Advance the remainder over the incoming byte
    assign updated = enable_reg ? crc24a_update(remainder_reg, in_item.in_byte)
                                : remainder_reg;

    always_comb
    begin
        remainder_next = remainder_reg;
        if (accept)
        begin
            remainder_next = in_item.in_last ? '0 : updated;
        end
    end

    // Build the entry handed to the back end
    always_comb
    begin
        q_entry.msg_byte = in_item.in_byte;
        q_entry.last     = in_item.in_last;
        q_entry.trailer  = enable_reg ? crc24a_reverse(updated) : '0;
    end

    // Hold the enable and the running remainder
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b1;
            remainder_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                enable_reg <= cfg_wdata;
            end
            remainder_reg <= remainder_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_item.in_last) |=> (remainder_reg == '0))
        else $error("remainder not cleared after last byte");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!accept) |=> (remainder_reg == $past(remainder_reg)))
        else $error("remainder moved without a transfer");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/crc24a_queue.sv
`default_nettype none

module crc24a_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    input  wire crc24a_pkg::queue_entry_t  push_entry,
    output logic                           full,
    input  wire logic                      pop,
    output crc24a_pkg::queue_status_t      status
);
    import crc24a_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    queue_entry_t     entry_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full             = (count_reg == CNT_W'(DEPTH));
    assign status.not_empty = (count_reg != '0);
    assign status.head      = entry_mem[rd_ptr_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && status.not_empty;

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Store the entry at the write pointer
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into a full queue");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/crc24a_back.sv
`default_nettype none

module crc24a_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire crc24a_pkg::queue_status_t status,
    output logic                           pop,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output crc24a_pkg::out_item_t          out_item
);
    import crc24a_pkg::*;

    typedef enum logic [1:0] {
        PH_ECHO,
        PH_TRL0,
        PH_TRL1,
        PH_TRL2
    } phase_t;

    phase_t                phase_reg;
    phase_t                phase_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    out_item_t             out_item_reg;
    out_item_t             out_item_next;
    logic                  load;
    logic [DATA_WIDTH-1:0] sel_byte;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Load the output register when the queue holds an entry and the register is free or being drained
    assign load = status.not_empty && (!out_valid_reg || !out_stall);

    // Pick the byte for the current phase of the head entry
    always_comb
    begin
        case (phase_reg)
            PH_ECHO: sel_byte = status.head.msg_byte;
            PH_TRL0: sel_byte = status.head.trailer[DATA_WIDTH-1:0];
            PH_TRL1: sel_byte = status.head.trailer[2*DATA_WIDTH-1:DATA_WIDTH];
            PH_TRL2: sel_byte = status.head.trailer[3*DATA_WIDTH-1:2*DATA_WIDTH];
            default: sel_byte = status.head.msg_byte;
        endcase
    end

    // Drop the head entry once its final byte is sent
    assign pop = load && ((phase_reg == PH_TRL2) ||
                          (phase_reg == PH_ECHO && !status.head.last));

    always_comb
    begin
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (load)
        begin
            out_valid_next         = 1'b1;
            out_item_next.out_byte = sel_byte;
            out_item_next.out_last = (phase_reg == PH_TRL2);
            if (pop)
            begin
                phase_next = PH_ECHO;
            end
            else
            begin
                case (phase_reg)
                    PH_ECHO: phase_next = PH_TRL0;
                    PH_TRL0: phase_next = PH_TRL1;
                    PH_TRL1: phase_next = PH_TRL2;
                    default: phase_next = PH_ECHO;
                endcase
            end
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold phase and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_ECHO;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            out_item_reg  <= out_item_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_trailer_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_ECHO) |-> (status.not_empty && status.head.last))
        else $error("trailer phase without a last entry at the head");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/crc24a_append_generator_core.sv
`default_nettype none

// CRC-24A append generator. Message bytes enter on the in channel, bit 0
// first, and leave unchanged on the out channel; after the byte flagged last
// three trailer bytes follow, holding the CRC-24A remainder (poly 0x1864CFB,
// zero start, no final inversion) with the x^23 term in bit 0 of the first
// trailer byte, and out_last marks the third. The remainder clears after each
// frame. cfg_we/cfg_wdata write the enable (reset 1); with it at 0 bytes do
// not enter the remainder and trailers are zero; write it only when idle.
// The front end takes one byte per cycle while the queue is not full and
// updates the remainder over all eight bits in that cycle; a QUEUE_DEPTH
// entry queue feeds the back end, whose single output register sends one
// byte per cycle while out_stall is low; a frame of N bytes gives N + 3
// output bytes. A byte is held in the queue, then in the output register.

module crc24a_append_generator_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_wdata,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire crc24a_pkg::in_item_t  in_item,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output crc24a_pkg::out_item_t      out_item
);
    import crc24a_pkg::*;

    logic          q_full;
    logic          q_push;
    logic          q_pop;
    queue_entry_t  q_entry;
    queue_status_t q_status;

    crc24a_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    crc24a_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .status     (q_status)
    );

    crc24a_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .status    (q_status),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire
